### rtl/core/eefa_pkg.sv
package eefa_pkg;

    localparam int FRAC_BITS = 53;
    localparam int EXP_BITS  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    // wide exponent keeps unpack and intermediate sums exact
    localparam int XW = EXP_BITS + 3;
    // working mantissa: quotient FRAC_BITS+3 bits, product 2*FRAC_BITS
    localparam int PW = 2 * FRAC_BITS;
    localparam int SW = FRAC_BITS + 4;
    localparam int DIV_STEPS = FRAC_BITS + 2;
    localparam int PIPE = DIV_STEPS + 4;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4,
        MODE_NEG = 3'd5
    } t_mode;

    typedef struct packed {
        logic                 sign;
        logic [FRAC_BITS-1:0] frac;
        logic signed [XW-1:0] exp;
        logic                 zero;
    } t_num;

    typedef struct packed {
        logic [2:0] mode;
        t_num       a;
        t_num       b;
    } t_item;

    typedef struct packed {
        logic                   sign;
        logic [FRAC_BITS-1:0]   frac;
        logic [EXP_BITS-1:0]    exp;
        logic                   less;
        logic                   equal;
        logic                   div_zero;
        logic                   exp_overflow;
    } t_result;

endpackage

### rtl/core/eefa_front.sv
module eefa_front
    import eefa_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [2:0]                 i_mode,
    input  logic                       i_a_sign,
    input  logic [FRAC_BITS-1:0]       i_a_frac,
    input  logic signed [EXP_BITS-1:0] i_a_exp,
    input  logic                       i_b_sign,
    input  logic [FRAC_BITS-1:0]       i_b_frac,
    input  logic signed [EXP_BITS-1:0] i_b_exp,
    output logic                       o_valid,
    output t_item                      o_item
);

    logic  r_valid;
    t_item r_item;

    function automatic t_num unpack(input logic s, input logic [FRAC_BITS-1:0] f,
                                    input logic signed [EXP_BITS-1:0] e);
        t_num n;
        int   t;
        t = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (f[i]) t = FRAC_BITS - 1 - i;
        end
        n.zero = (f == '0);
        n.sign = n.zero ? 1'b0 : s;
        n.frac = n.zero ? '0 : (f << t);
        n.exp  = n.zero ? '0 : (XW'(e) - XW'(t));
        return n;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
        r_item <= '{mode: i_mode,
                    a: unpack(i_a_sign, i_a_frac, i_a_exp),
                    b: unpack(i_b_sign, i_b_frac, i_b_exp)};
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/eefa_queue.sv
module eefa_queue
    import eefa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output logic   o_valid,
    output t_item  o_item,
    output logic   o_full
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic do_pop;

    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(do_pop);
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

### rtl/core/eefa_back.sv
module eefa_back
    import eefa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_res
);

    localparam logic signed [XW-1:0] EMAX = XW'((64'sd1 <<< (EXP_BITS-1)) - 1);
    localparam logic signed [XW-1:0] EMIN = -EMAX - XW'(1);
    // fraction split for the partial products
    localparam int MLO = (FRAC_BITS + 1) / 2;
    localparam int MHI = FRAC_BITS - MLO;

    // stage 1: align / multiply / divide setup, compare, negate
    typedef struct packed {
        logic [2:0]           mode;
        logic                 sign;
        logic [PW-1:0]        r;
        logic                 sticky;
        logic signed [XW-1:0] x;
        logic                 zero;
        logic                 dz;
        logic                 less;
        logic                 equal;
        logic [FRAC_BITS-1:0] bf;
        logic [FRAC_BITS:0]   rem;
        logic [FRAC_BITS:0]   mid;
    } t_st;

    t_st  r_st [PIPE];
    logic r_v  [PIPE];
    t_result r_res;
    logic    r_out;

    function automatic t_st stage_in(input t_item it);
        t_st  s;
        t_num a, b, big, sml;
        logic signed [XW-1:0] d;
        logic [SW-1:0] lb, ls, full, sum;
        logic bs;
        logic [2*MHI-1:0] p_hh;
        logic [2*MLO-1:0] p_ll;
        s = '0;
        s.mode = it.mode;
        a = it.a;
        b = it.b;
        bs = b.sign ^ (it.mode == MODE_SUB);
        b.sign = bs & ~b.zero;
        unique case (it.mode)
            MODE_ADD, MODE_SUB: begin
                if (a.zero && b.zero) begin
                    s.zero = 1'b1;
                end else if (a.zero || b.zero) begin
                    big = a.zero ? b : a;
                    s.sign = big.sign;
                    s.r = PW'(big.frac);
                    s.x = big.exp - XW'(FRAC_BITS);
                end else begin
                    if (a.exp >= b.exp) begin big = a; sml = b; end
                    else begin big = b; sml = a; end
                    d = big.exp - sml.exp;
                    lb = SW'({big.frac, 3'b000});
                    full = SW'({sml.frac, 3'b000});
                    if (d >= XW'(FRAC_BITS + 3)) begin
                        ls = SW'(1);
                    end else begin
                        ls = full >> d[5:0];
                        if ((full & ((SW'(1) << d[5:0]) - SW'(1))) != '0) ls[0] = 1'b1;
                    end
                    if (big.sign == sml.sign) begin
                        sum = lb + ls; s.sign = big.sign;
                    end else if (ls > lb) begin
                        sum = ls - lb; s.sign = sml.sign;
                    end else begin
                        sum = lb - ls; s.sign = big.sign;
                    end
                    s.zero = (sum == '0);
                    s.r = PW'(sum);
                    s.x = big.exp - XW'(FRAC_BITS + 3);
                end
            end
            MODE_MUL: begin
                s.zero = a.zero || b.zero;
                s.sign = a.sign ^ b.sign;
                // outer partial products now, cross terms folded in later
                p_hh = (2*MHI)'(a.frac[FRAC_BITS-1:MLO]) * (2*MHI)'(b.frac[FRAC_BITS-1:MLO]);
                p_ll = (2*MLO)'(a.frac[MLO-1:0]) * (2*MLO)'(b.frac[MLO-1:0]);
                s.r = {p_hh, p_ll};
                s.mid = (FRAC_BITS+1)'(a.frac[FRAC_BITS-1:MLO]) * (FRAC_BITS+1)'(b.frac[MLO-1:0])
                      + (FRAC_BITS+1)'(a.frac[MLO-1:0]) * (FRAC_BITS+1)'(b.frac[FRAC_BITS-1:MLO]);
                s.x = a.exp + b.exp - XW'(2 * FRAC_BITS);
            end
            MODE_DIV: begin
                s.dz = b.zero;
                s.zero = a.zero || b.zero;
                s.sign = a.sign ^ b.sign;
                s.bf = b.frac;
                s.r[0] = (a.frac >= b.frac);
                s.rem = (FRAC_BITS+1)'(a.frac) - (s.r[0] ? (FRAC_BITS+1)'(b.frac) : '0);
                s.x = a.exp - b.exp - XW'(FRAC_BITS + 2);
            end
            MODE_CMP: begin
                s.zero = 1'b1;
                if (a.zero && b.zero) s.equal = 1'b1;
                else if (a.zero) s.less = ~b.sign;
                else if (b.zero) s.less = a.sign;
                else if (a.sign != b.sign) s.less = a.sign;
                else if (a.exp == b.exp && a.frac == b.frac) s.equal = 1'b1;
                else s.less = a.sign ^ ((a.exp < b.exp) ||
                              (a.exp == b.exp && a.frac < b.frac));
            end
            MODE_NEG: begin
                s.zero = a.zero;
                s.sign = ~a.sign;
                s.r = PW'(a.frac);
                s.x = a.exp - XW'(FRAC_BITS);
            end
            default: s.zero = 1'b1;
        endcase
        return s;
    endfunction

    // one restoring divide step per stage; others pass through
    function automatic t_st div_step(input t_st s);
        t_st o;
        logic [FRAC_BITS+1:0] t;
        o = s;
        if (s.mode == MODE_DIV) begin
            t = {s.rem, 1'b0};
            o.r = {s.r[PW-2:0], 1'b0};
            if (t >= (FRAC_BITS+2)'(s.bf)) begin
                t = t - (FRAC_BITS+2)'(s.bf);
                o.r[0] = 1'b1;
            end
            o.rem = t[FRAC_BITS:0];
        end
        return o;
    endfunction

    // take the divide sticky bit and fold the multiplier cross terms in
    function automatic t_st stage_fix(input t_st s);
        t_st o;
        o = s;
        if (s.mode == MODE_DIV) o.sticky = (s.rem != '0);
        if (s.mode == MODE_MUL) o.r = s.r + (PW'(s.mid) << MLO);
        return o;
    endfunction

    // sticky from divide remainder, then normalise to leading one at bit FRAC_BITS-1
    typedef struct packed {
        t_st          s;
        logic [6:0]   p;
    } t_nm;
    t_nm r_nm;
    t_nm r_sh;

    function automatic logic [6:0] msb(input logic [PW-1:0] v);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < PW; i++) if (v[i]) p = 7'(i);
        return p;
    endfunction

    function automatic t_result finish(input t_nm n);
        t_result o;
        t_st s;
        logic [PW-1:0] v, rem, half;
        logic [FRAC_BITS:0] f;
        logic signed [XW-1:0] x;
        int sh;
        s = n.s;
        o = '0;
        o.less = s.less;
        o.equal = s.equal;
        o.div_zero = s.dz;
        v = s.r;
        x = s.x;
        if (!s.zero) begin
            if (n.p > 7'(FRAC_BITS - 1)) begin
                sh = int'(n.p) - (FRAC_BITS - 1);
                rem = v & ((PW'(1) << sh) - PW'(1));
                half = PW'(1) << (sh - 1);
                f = (FRAC_BITS+1)'(v >> sh);
                if (rem > half || (rem == half && (s.sticky || f[0]))) f = f + 1'b1;
                x = x + XW'(sh);
                if (f[FRAC_BITS]) begin
                    f = f >> 1;
                    x = x + XW'(1);
                end
            end else begin
                sh = (FRAC_BITS - 1) - int'(n.p);
                f = (FRAC_BITS+1)'(v << sh);
                x = x - XW'(sh);
            end
            x = x + XW'(FRAC_BITS);
            if (x > EMAX) begin
                o.sign = s.sign;
                o.frac = '1;
                o.exp = EMAX[EXP_BITS-1:0];
                o.exp_overflow = 1'b1;
            end else if (x < EMIN) begin
                o.exp_overflow = 1'b1;
            end else begin
                o.sign = s.sign;
                o.frac = f[FRAC_BITS-1:0];
                o.exp = x[EXP_BITS-1:0];
            end
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE; i++) r_v[i] <= 1'b0;
            r_out <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int i = 1; i < PIPE; i++) r_v[i] <= r_v[i-1];
            r_out <= r_v[PIPE-1];
        end
        r_st[0] <= stage_in(i_item);
        for (int i = 1; i <= DIV_STEPS; i++) r_st[i] <= div_step(r_st[i-1]);
        r_st[DIV_STEPS+1] <= stage_fix(r_st[DIV_STEPS]);
        for (int i = DIV_STEPS + 2; i < PIPE; i++) r_st[i] <= r_st[i-1];
        r_nm <= '{s: r_st[PIPE-1], p: msb(r_st[PIPE-1].r)};
        r_sh <= r_nm;
        r_res <= finish(r_sh);
    end

    // normalise and round trail the pipe in r_nm, r_sh, r_res; r_out, r_v1, r_v2 carry valid
    logic r_v1, r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= r_out;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_res   = r_res;

endmodule

### rtl/core/extended_exponent_float_alu_core.sv
// Path from accepted start to o_done: front register, queue, then the back-end pipe
// (setup, divide pipe of FRAC_BITS+2 restoring steps, fix-up, normalise, round).
// Throughput: one item per cycle; the divider is fully pipelined.
// The receiver cannot stall, so busy never rises in steady operation.
// Reset (synchronous, active low) clears all valid flags and the queue.
module extended_exponent_float_alu_core
    import eefa_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_mode,
    input  logic                       i_a_sign,
    input  logic [FRAC_BITS-1:0]       i_a_frac,
    input  logic signed [EXP_BITS-1:0] i_a_exp,
    input  logic                       i_b_sign,
    input  logic [FRAC_BITS-1:0]       i_b_frac,
    input  logic signed [EXP_BITS-1:0] i_b_exp,
    output logic                       o_done,
    output logic                       o_r_sign,
    output logic [FRAC_BITS-1:0]       o_r_frac,
    output logic signed [EXP_BITS-1:0] o_r_exp,
    output logic                       o_less,
    output logic                       o_equal,
    output logic                       o_div_zero,
    output logic                       o_exp_overflow
);

    logic    take, f_valid, q_valid, q_full;
    t_item   f_item, q_item;
    t_result res;

    assign take = start && !busy;
    // back end never stalls, so the queue drains every cycle
    assign busy = q_full;

    eefa_front u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_mode, .i_a_sign, .i_a_frac, .i_a_exp,
        .i_b_sign, .i_b_frac, .i_b_exp, .o_valid(f_valid), .o_item(f_item)
    );

    eefa_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_item(f_item), .i_pop(1'b1),
        .o_valid(q_valid), .o_item(q_item), .o_full(q_full)
    );

    eefa_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_item(q_item),
        .o_valid(o_done), .o_res(res)
    );

    assign o_r_sign       = res.sign;
    assign o_r_frac       = res.frac;
    assign o_r_exp        = res.exp;
    assign o_less         = res.less;
    assign o_equal        = res.equal;
    assign o_div_zero     = res.div_zero;
    assign o_exp_overflow = res.exp_overflow;

`ifndef SYNTHESIS
    a_no_full: assert property (@(posedge i_clk) disable iff (!i_rst_n) !q_full)
        else $error("queue filled although back end never stalls");
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_less || o_equal) |-> !o_div_zero && !o_exp_overflow && o_r_frac == '0)
        else $error("compare result carries arithmetic fields");
    a_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_r_frac == '0 |-> o_r_exp == '0 && !o_r_sign)
        else $error("zero result with nonzero exponent or sign");
`endif

endmodule

### tb/sv/tb_extended_exponent_float_alu_core.sv
`timescale 1ns / 100ps

module tb_extended_exponent_float_alu_core;
    import eefa_pkg::*;

    localparam int       WATCHDOG_LIMIT = 5000;
    localparam int       DRAIN_CYCLES   = PIPE + 20;
    localparam longint   EXP_TOP        = 64'sd2147483647;
    localparam longint   EXP_BOTTOM     = -64'sd2147483648;
    localparam bit [63:0] FRAC_ALL      = (64'd1 << FRAC_BITS) - 64'd1;

    typedef struct {
        logic [2:0]                 mode;
        logic                       a_sign;
        logic [FRAC_BITS-1:0]       a_frac;
        logic signed [EXP_BITS-1:0] a_exp;
        logic                       b_sign;
        logic [FRAC_BITS-1:0]       b_frac;
        logic signed [EXP_BITS-1:0] b_exp;
    } t_op_pair;

    typedef struct {
        bit        sign;
        bit [63:0] frac;
        longint    ex;
        bit        ovf;
    } t_wide_num;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [2:0]                 i_mode = '0;
    logic                       i_a_sign = 1'b0;
    logic [FRAC_BITS-1:0]       i_a_frac = '0;
    logic signed [EXP_BITS-1:0] i_a_exp = '0;
    logic                       i_b_sign = 1'b0;
    logic [FRAC_BITS-1:0]       i_b_frac = '0;
    logic signed [EXP_BITS-1:0] i_b_exp = '0;
    logic                       o_done;
    logic                       o_r_sign;
    logic [FRAC_BITS-1:0]       o_r_frac;
    logic signed [EXP_BITS-1:0] o_r_exp;
    logic                       o_less;
    logic                       o_equal;
    logic                       o_div_zero;
    logic                       o_exp_overflow;

    t_op_pair pending_ops[$];
    t_result  expected_results[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;

    extended_exponent_float_alu_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_a_sign(i_a_sign), .i_a_frac(i_a_frac), .i_a_exp(i_a_exp),
        .i_b_sign(i_b_sign), .i_b_frac(i_b_frac), .i_b_exp(i_b_exp),
        .o_done(o_done), .o_r_sign(o_r_sign), .o_r_frac(o_r_frac), .o_r_exp(o_r_exp),
        .o_less(o_less), .o_equal(o_equal), .o_div_zero(o_div_zero),
        .o_exp_overflow(o_exp_overflow)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- arithmetic predictor ----------------
    function automatic int top_bit(bit [63:0] v);
        int p;
        p = 0;
        for (int k = 0; k < 64; k++) begin
            if (v[k]) p = k;
        end
        return p;
    endfunction

    function automatic t_wide_num zero_val();
        t_wide_num z;
        z.sign = 1'b0; z.frac = 64'd0; z.ex = 0; z.ovf = 1'b0;
        return z;
    endfunction

    function automatic t_wide_num normalise_in(bit s, bit [FRAC_BITS-1:0] f,
                                               logic signed [EXP_BITS-1:0] e);
        t_wide_num n;
        int t;
        n = zero_val();
        if (f == 0) return n;
        t = (FRAC_BITS - 1) - top_bit(64'(f));
        n.sign = s;
        n.frac = 64'(f) << t;
        n.ex = longint'(e) - t;
        return n;
    endfunction

    function automatic t_wide_num clamp_range(t_wide_num n);
        if (n.frac == 0) return zero_val();
        if (n.ex > EXP_TOP) begin
            n.frac = FRAC_ALL;
            n.ex = EXP_TOP;
            n.ovf = 1'b1;
        end else if (n.ex < EXP_BOTTOM) begin
            n = zero_val();
            n.ovf = 1'b1;
        end
        return n;
    endfunction

    function automatic t_wide_num round_even(bit s, bit [63:0] r, bit sticky, longint x);
        t_wide_num n;
        int        p;
        int        sh;
        bit [63:0] rem;
        bit [63:0] half;
        bit [63:0] f;
        n = zero_val();
        p = top_bit(r);
        if (p > FRAC_BITS - 1) begin
            sh = p - (FRAC_BITS - 1);
            rem = r & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            f = r >> sh;
            if (rem > half || (rem == half && (sticky || f[0]))) f = f + 64'd1;
            x = x + sh;
            if (f == (64'd1 << FRAC_BITS)) begin
                f = f >> 1;
                x = x + 1;
            end
        end else begin
            sh = (FRAC_BITS - 1) - p;
            f = r << sh;
            x = x - sh;
        end
        n.sign = s;
        n.frac = f;
        n.ex = x + FRAC_BITS;
        return clamp_range(n);
    endfunction

    function automatic t_wide_num sum_of(t_wide_num a, t_wide_num b);
        t_wide_num big, sml;
        bit [63:0] lb, ls, full, r;
        longint    d;
        bit        s;
        if (a.frac == 0) return clamp_range(b);
        if (b.frac == 0) return clamp_range(a);
        if (a.ex >= b.ex) begin
            big = a; sml = b;
        end else begin
            big = b; sml = a;
        end
        d = big.ex - sml.ex;
        lb = big.frac << 3;
        if (d >= FRAC_BITS + 3) begin
            ls = 64'd1;
        end else begin
            full = sml.frac << 3;
            ls = full >> d;
            if (d > 0 && (full & ((64'd1 << d) - 64'd1)) != 0) ls[0] = 1'b1;
        end
        if (big.sign == sml.sign) begin
            r = lb + ls; s = big.sign;
        end else if (ls > lb) begin
            r = ls - lb; s = sml.sign;
        end else begin
            r = lb - ls; s = big.sign;
        end
        if (r == 0) return zero_val();
        return round_even(s, r, 1'b0, big.ex - FRAC_BITS - 3);
    endfunction

    function automatic t_wide_num product_of(t_wide_num a, t_wide_num b);
        bit [127:0] prod;
        if (a.frac == 0 || b.frac == 0) return zero_val();
        prod = 128'(a.frac) * 128'(b.frac);
        return round_even(a.sign ^ b.sign, 64'(prod >> (FRAC_BITS - 3)),
                          (prod & ((128'd1 << (FRAC_BITS - 3)) - 1)) != 0,
                          a.ex + b.ex - FRAC_BITS - 3);
    endfunction

    function automatic t_wide_num quotient_of(t_wide_num a, t_wide_num b);
        bit [63:0] q, r;
        q = (a.frac >= b.frac) ? 64'd1 : 64'd0;
        r = a.frac - (q[0] ? b.frac : 64'd0);
        for (int k = 0; k < FRAC_BITS + 2; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b.frac) begin
                r = r - b.frac;
                q[0] = 1'b1;
            end
        end
        return round_even(a.sign ^ b.sign, q, r != 0, a.ex - b.ex - FRAC_BITS - 2);
    endfunction

    function automatic t_result predict_alu(t_op_pair op);
        t_wide_num a, b, r;
        t_result   res;
        int        order;
        a = normalise_in(op.a_sign, op.a_frac, op.a_exp);
        b = normalise_in(op.b_sign, op.b_frac, op.b_exp);
        r = zero_val();
        res = '0;
        case (op.mode)
            MODE_ADD: r = sum_of(a, b);
            MODE_SUB: begin
                b.sign = ~b.sign;
                r = sum_of(a, b);
            end
            MODE_MUL: r = product_of(a, b);
            MODE_DIV: begin
                if (b.frac == 0) res.div_zero = 1'b1;
                else if (a.frac != 0) r = quotient_of(a, b);
            end
            MODE_CMP: begin
                if (a.frac == 0 && b.frac == 0) res.equal = 1'b1;
                else if (a.frac == 0) res.less = ~b.sign;
                else if (b.frac == 0) res.less = a.sign;
                else if (a.sign != b.sign) res.less = a.sign;
                else begin
                    if (a.ex != b.ex) order = (a.ex < b.ex) ? -1 : 1;
                    else if (a.frac != b.frac) order = (a.frac < b.frac) ? -1 : 1;
                    else order = 0;
                    if (order == 0) res.equal = 1'b1;
                    else res.less = a.sign ? (order > 0) : (order < 0);
                end
            end
            MODE_NEG: begin
                a.sign = ~a.sign;
                r = clamp_range(a);
            end
            default: ;
        endcase
        if (r.frac == 0) r.sign = 1'b0;
        res.sign = r.sign;
        res.frac = r.frac[FRAC_BITS-1:0];
        res.exp = r.ex[EXP_BITS-1:0];
        res.exp_overflow = r.ovf;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [FRAC_BITS-1:0] rand_frac();
        logic [63:0] raw;
        int          pick;
        raw = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return raw[FRAC_BITS-1:0] >> $urandom_range(1, 52);
        if (pick == 2) return raw[FRAC_BITS-1:0];
        if (pick == 3) return {1'b1, {(FRAC_BITS-1){raw[0]}}};
        return {1'b1, raw[FRAC_BITS-2:0]};
    endfunction

    function automatic logic signed [EXP_BITS-1:0] rand_exp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return $urandom;
        if (pick == 1) return 32'sh7FFF_FFFF - $urandom_range(0, 60);
        if (pick == 2) return 32'sh8000_0000 + $urandom_range(0, 60);
        if (pick == 3) return 32'sh4000_0000 - $urandom_range(0, 200);
        if (pick == 4) return -32'sh4000_0000 + $urandom_range(0, 200);
        return $signed($urandom_range(0, 400)) - 200;
    endfunction

    function automatic t_op_pair rand_op();
        t_op_pair op;
        op.mode = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        op.a_sign = 1'($urandom);
        op.b_sign = 1'($urandom);
        op.a_frac = rand_frac();
        op.b_frac = rand_frac();
        op.a_exp = rand_exp();
        // keep exponents close half the time so alignment and cancellation get hit
        if ($urandom_range(0, 1)) op.b_exp = op.a_exp + $signed($urandom_range(0, 120)) - 60;
        else op.b_exp = rand_exp();
        if ($urandom_range(0, 7) == 0) begin
            op.b_frac = op.a_frac ^ FRAC_BITS'($urandom_range(0, 3));
            op.b_exp = op.a_exp;
        end
        return op;
    endfunction

    function automatic t_op_pair mk_op(logic [2:0] m, logic as, logic [FRAC_BITS-1:0] af,
                                       logic signed [EXP_BITS-1:0] ae, logic bs,
                                       logic [FRAC_BITS-1:0] bf,
                                       logic signed [EXP_BITS-1:0] be);
        t_op_pair op;
        op.mode = m; op.a_sign = as; op.a_frac = af; op.a_exp = ae;
        op.b_sign = bs; op.b_frac = bf; op.b_exp = be;
        return op;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_alu(mk_op(i_mode, i_a_sign, i_a_frac,
                    i_a_exp, i_b_sign, i_b_frac, i_b_exp)));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    t_op_pair op;
                    op = pending_ops.pop_front();
                    i_mode <= op.mode;
                    i_a_sign <= op.a_sign;
                    i_a_frac <= op.a_frac;
                    i_a_exp <= op.a_exp;
                    i_b_sign <= op.b_sign;
                    i_b_frac <= op.b_frac;
                    i_b_exp <= op.b_exp;
                    start <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                error_count++;
            end else begin
                t_result want;
                want = expected_results.pop_front();
                if (o_r_sign !== want.sign)
                    report_mismatch("r_sign", 64'(o_r_sign), 64'(want.sign));
                if (o_r_frac !== want.frac)
                    report_mismatch("r_frac", 64'(o_r_frac), 64'(want.frac));
                if (o_r_exp !== want.exp)
                    report_mismatch("r_exp", 64'(unsigned'(o_r_exp)), 64'(want.exp));
                if (o_less !== want.less)
                    report_mismatch("less", 64'(o_less), 64'(want.less));
                if (o_equal !== want.equal)
                    report_mismatch("equal", 64'(o_equal), 64'(want.equal));
                if (o_div_zero !== want.div_zero)
                    report_mismatch("div_zero", 64'(o_div_zero), 64'(want.div_zero));
                if (o_exp_overflow !== want.exp_overflow)
                    report_mismatch("exp_overflow", 64'(o_exp_overflow),
                                    64'(want.exp_overflow));
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [FRAC_BITS-1:0] one_frac;
        logic [FRAC_BITS-1:0] top_frac;
        one_frac = {1'b1, {(FRAC_BITS-1){1'b0}}};
        top_frac = {FRAC_BITS{1'b1}};
        // directed: every mode, extremes, zeros, unnormalised inputs, overflow both ways
        pending_ops.push_back(mk_op(MODE_ADD, 1'b0, one_frac, 1, 1'b0, one_frac, 1));
        pending_ops.push_back(mk_op(MODE_ADD, 1'b0, top_frac, 32'sh7FFF_FFFF, 1'b0, top_frac,
                                    32'sh7FFF_FFFF));
        pending_ops.push_back(mk_op(MODE_SUB, 1'b1, top_frac, 5, 1'b1, top_frac, 5));
        pending_ops.push_back(mk_op(MODE_SUB, 1'b0, one_frac, 32'sh8000_0000, 1'b0, top_frac,
                                    32'sh8000_0000));
        pending_ops.push_back(mk_op(MODE_ADD, 1'b0, one_frac, 0, 1'b1, 53'd1, -100));
        pending_ops.push_back(mk_op(MODE_ADD, 1'b1, 53'd0, 77, 1'b0, 53'd5, 3));
        pending_ops.push_back(mk_op(MODE_MUL, 1'b0, top_frac, 32'sh7FFF_FFFF, 1'b1, top_frac,
                                    2));
        pending_ops.push_back(mk_op(MODE_MUL, 1'b1, one_frac, 32'sh8000_0000, 1'b0, one_frac,
                                    -3));
        pending_ops.push_back(mk_op(MODE_MUL, 1'b1, 53'd0, 9, 1'b0, top_frac, 4));
        pending_ops.push_back(mk_op(MODE_MUL, 1'b1, top_frac, 0, 1'b1, top_frac, 0));
        pending_ops.push_back(mk_op(MODE_DIV, 1'b0, one_frac, 1, 1'b1, 53'd0, 1));
        pending_ops.push_back(mk_op(MODE_DIV, 1'b1, 53'd0, 1, 1'b0, one_frac, 1));
        pending_ops.push_back(mk_op(MODE_DIV, 1'b0, top_frac, 32'sh7FFF_FFFF, 1'b0, one_frac,
                                    32'sh8000_0000));
        pending_ops.push_back(mk_op(MODE_DIV, 1'b1, one_frac, 32'sh8000_0000, 1'b0, top_frac,
                                    32'sh7FFF_FFFF));
        pending_ops.push_back(mk_op(MODE_DIV, 1'b0, one_frac, 0, 1'b0, {2'b11, 51'd0}, 0));
        pending_ops.push_back(mk_op(MODE_CMP, 1'b1, 53'd0, 3, 1'b0, 53'd0, 9));
        pending_ops.push_back(mk_op(MODE_CMP, 1'b1, top_frac, 4, 1'b1, one_frac, 4));
        pending_ops.push_back(mk_op(MODE_CMP, 1'b0, one_frac, 4, 1'b1, one_frac, 4));
        pending_ops.push_back(mk_op(MODE_CMP, 1'b0, 53'd3, 0, 1'b0, one_frac, -50));
        pending_ops.push_back(mk_op(MODE_CMP, 1'b1, 53'd0, 0, 1'b1, top_frac, 8));
        pending_ops.push_back(mk_op(MODE_NEG, 1'b0, 53'd1, 32'sh8000_0000, 1'b1, top_frac, 0));
        pending_ops.push_back(mk_op(MODE_NEG, 1'b1, top_frac, 32'sh7FFF_FFFF, 1'b0, 53'd0, 0));
        pending_ops.push_back(mk_op(MODE_NEG, 1'b0, 53'd0, 12, 1'b0, 53'd0, 0));
        pending_ops.push_back(mk_op(3'd6, 1'b1, top_frac, -1, 1'b1, top_frac, -1));
        pending_ops.push_back(mk_op(3'd7, 1'b1, one_frac, 2, 1'b0, one_frac, 2));
        for (int k = 0; k < 1425; k++) pending_ops.push_back(rand_op());

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
